@@ design/mms_pkg.sv @@
package mms_pkg;

    localparam logic [1:0] OP_INSERT    = 2'd0;
    localparam logic [1:0] OP_ERASE_ALL = 2'd1;
    localparam logic [1:0] OP_ERASE_ONE = 2'd2;
    localparam logic [1:0] OP_COUNT     = 2'd3;

    localparam int FIELD_W = 5;

    typedef struct packed {
        logic       vld;
        logic [1:0] op;
        logic       placed;
        logic       found;
    } t_ctl;

endpackage

@@ design/mms_cell.sv @@
module mms_cell #(
    parameter int VALUE_WIDTH = 32,
    parameter int CNT_W       = 5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  mms_pkg::t_ctl          i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_key,
    input  logic [CNT_W-1:0]       i_cnt,
    output mms_pkg::t_ctl          o_ctl,
    output logic [VALUE_WIDTH-1:0] o_key,
    output logic [CNT_W-1:0]       o_cnt
);
    import mms_pkg::*;

    logic [VALUE_WIDTH-1:0] r_val;
    logic [VALUE_WIDTH-1:0] n_val;
    logic                   r_valid;
    logic                   n_valid;
    t_ctl                   r_ctl;
    t_ctl                   n_ctl;
    logic [VALUE_WIDTH-1:0] r_key;
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       n_cnt;
    logic                   w_match;

    assign w_match = r_valid && (r_val == i_key);

    always_comb begin
        n_val   = r_val;
        n_valid = r_valid;
        n_ctl   = i_ctl;
        n_cnt   = i_cnt;
        if (i_ctl.vld) begin
            case (i_ctl.op)
                OP_INSERT: begin
                    if (!i_ctl.placed && !r_valid) begin
                        n_val        = i_key;
                        n_valid      = 1'b1;
                        n_ctl.placed = 1'b1;
                    end
                end
                OP_ERASE_ALL: begin
                    if (w_match) begin
                        n_valid = 1'b0;
                        n_cnt   = i_cnt + CNT_W'(1);
                    end
                end
                OP_ERASE_ONE: begin
                    if (w_match && !i_ctl.found) begin
                        n_valid     = 1'b0;
                        n_ctl.found = 1'b1;
                    end
                end
                OP_COUNT: begin
                    if (w_match) begin
                        n_cnt = i_cnt + CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ctl   <= '0;
        end else if (i_en) begin
            r_valid <= n_valid;
            r_ctl   <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= n_val;
            r_key <= i_key;
            r_cnt <= n_cnt;
        end
    end

    assign o_ctl = r_ctl;
    assign o_key = r_key;
    assign o_cnt = r_cnt;

endmodule

@@ design/multiset_match_store.sv @@
// Bounded multiset of CAPACITY values. Each item carries an opcode (insert,
// erase all copies, erase one copy, count copies) and a value, and yields one
// result with the copies removed or counted, an erase-one found flag, the
// occupancy after the command and a full-store reject status. The store is a
// row of CAPACITY cells; a command walks the row one cell per cycle unless the
// row holds; its result is registered behind the last cell. Commands follow
// each other down the row, so one item is accepted per cycle while the result
// side keeps taking results. The whole row holds while a result waits.
module multiset_match_store #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] item_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [4:0] matched_count, [5] found,
                                        // [10:6] occupancy, [11] status
);
    import mms_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_ctl                   w_ctl [CAPACITY+1];
    logic [VALUE_WIDTH-1:0] w_key [CAPACITY+1];
    logic [CNT_W-1:0]       w_cnt [CAPACITY+1];

    logic                   w_en;
    logic                   r_out_valid;
    logic [FIELD_W-1:0]     r_matched;
    logic                   r_found;
    logic [FIELD_W-1:0]     r_occ;
    logic                   r_status;
    logic [CNT_W-1:0]       r_held;
    logic [CNT_W-1:0]       n_held;
    logic                   w_status;
    t_ctl                   w_last;

    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    always_comb begin
        w_ctl[0]        = '0;
        w_ctl[0].vld    = s_axis_tvalid && w_en;
        w_ctl[0].op     = s_axis_tuser;
        w_ctl[0].placed = 1'b0;
        w_ctl[0].found  = 1'b0;
    end
    assign w_key[0] = VALUE_WIDTH'(s_axis_tdata);
    assign w_cnt[0] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        mms_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .CNT_W       (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[g]),
            .i_key   (w_key[g]),
            .i_cnt   (w_cnt[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_key   (w_key[g+1]),
            .o_cnt   (w_cnt[g+1])
        );
    end

    assign w_last = w_ctl[CAPACITY];

    always_comb begin
        n_held   = r_held;
        w_status = 1'b0;
        case (w_last.op)
            OP_INSERT: begin
                if (w_last.placed) begin
                    n_held = r_held + CNT_W'(1);
                end else begin
                    w_status = 1'b1;
                end
            end
            OP_ERASE_ALL: n_held = r_held - w_cnt[CAPACITY];
            OP_ERASE_ONE: begin
                if (w_last.found) begin
                    n_held = r_held - CNT_W'(1);
                end
            end
            default: n_held = r_held;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_held      <= '0;
        end else if (w_en) begin
            r_out_valid <= w_last.vld;
            if (w_last.vld) begin
                r_held <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_last.vld) begin
            r_matched <= FIELD_W'(w_cnt[CAPACITY]);
            r_found   <= w_last.found;
            r_occ     <= FIELD_W'(n_held);
            r_status  <= w_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_status, r_occ, r_found, r_matched};

endmodule

@@ design/mms_checker.sv @@
module mms_checker #(
    parameter int CAPACITY = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[11] |->
            m_axis_tdata[10:6] == 5'(CAPACITY) && m_axis_tdata[4:0] == 5'd0
            && !m_axis_tdata[5])
        else $error("reject without a full store");

    a_found_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[5] |->
            m_axis_tdata[4:0] == 5'd0 && !m_axis_tdata[11])
        else $error("found with count or status set");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (CAPACITY >= 32) || (int'(m_axis_tdata[10:6]) <= CAPACITY))
        else $error("occupancy above capacity");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind multiset_match_store mms_checker #(
    .CAPACITY (CAPACITY)
) u_mms_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import mms_pkg::*;

    localparam int STORE_DEPTH  = 16;
    localparam int VAL_W        = 32;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 48;
    localparam int RANDOM_ITEMS = 1250;
    localparam int POOL_SIZE    = 6;

    typedef struct packed {
        logic       status;
        logic [4:0] occupancy;
        logic       found;
        logic [4:0] matched;
    } t_bag_result;

    class bag_scoreboard;
        logic [VAL_W-1:0] slot_val [STORE_DEPTH];
        bit               slot_vld [STORE_DEPTH];
        int unsigned      held;
        t_bag_result      pending_q [$];
        int unsigned      mismatches;

        function new();
            held       = 0;
            mismatches = 0;
            foreach (slot_vld[i]) begin
                slot_vld[i] = 1'b0;
                slot_val[i] = '0;
            end
        endfunction

        function void note_command(logic [1:0] op, logic [31:0] value);
            t_bag_result      res;
            logic [VAL_W-1:0] key;
            bit               done;
            int unsigned      hits;
            res  = '0;
            key  = value[VAL_W-1:0];
            done = 1'b0;
            hits = 0;
            case (op)
                OP_INSERT: begin
                    foreach (slot_vld[i]) begin
                        if (!done && !slot_vld[i]) begin
                            slot_val[i] = key;
                            slot_vld[i] = 1'b1;
                            held++;
                            done = 1'b1;
                        end
                    end
                    res.status = !done;
                end
                OP_ERASE_ALL: begin
                    foreach (slot_vld[i]) begin
                        if (slot_vld[i] && slot_val[i] == key) begin
                            slot_vld[i] = 1'b0;
                            hits++;
                        end
                    end
                    held -= hits;
                    res.matched = hits[4:0];
                end
                OP_ERASE_ONE: begin
                    foreach (slot_vld[i]) begin
                        if (!done && slot_vld[i] && slot_val[i] == key) begin
                            slot_vld[i] = 1'b0;
                            held--;
                            done = 1'b1;
                        end
                    end
                    res.found = done;
                end
                OP_COUNT: begin
                    foreach (slot_vld[i]) begin
                        if (slot_vld[i] && slot_val[i] == key)
                            hits++;
                    end
                    res.matched = hits[4:0];
                end
                default: ;
            endcase
            res.occupancy = held[4:0];
            pending_q.push_back(res);
        endfunction

        function void flag(string what, int want_v, int got_v);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what,
                         want_v, got_v);
        endfunction

        function void check_result(logic [15:0] data);
            t_bag_result got;
            t_bag_result want;
            got = data[11:0];
            if (pending_q.size() == 0) begin
                flag("unexpected result (tdata)", -1, data);
            end else begin
                want = pending_q.pop_front();
                if (got.matched !== want.matched)
                    flag("matched_count", want.matched, got.matched);
                if (got.found !== want.found)
                    flag("found", want.found, got.found);
                if (got.occupancy !== want.occupancy)
                    flag("occupancy", want.occupancy, got.occupancy);
                if (got.status !== want.status)
                    flag("status", want.status, got.status);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] item_value
    logic [1:0]  s_axis_tuser = '0;   // [1:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [4:0] matched_count, [5] found,
                                      // [10:6] occupancy, [11] status

    bag_scoreboard sb;
    int unsigned   burst_left = 0;
    int unsigned   idle_cycles = 0;
    logic [31:0]   stall_mask = '1;
    logic [4:0]    stall_phase = '0;
    logic [31:0]   value_pool [POOL_SIZE];

    always #10 i_clk = ~i_clk;

    multiset_match_store #(
        .CAPACITY    (STORE_DEPTH),
        .VALUE_WIDTH (VAL_W)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    task automatic send_command(input logic [1:0] op, input logic [31:0] value);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_command(op, value);
        burst_left--;
    endtask

    task automatic run_directed();
        send_command(OP_ERASE_ONE, 32'h0000_0000);
        send_command(OP_COUNT,     32'hFFFF_FFFF);
        send_command(OP_INSERT,    32'h0000_0000);
        send_command(OP_INSERT,    32'hFFFF_FFFF);
        send_command(OP_INSERT,    32'hFFFF_FFFF);
        send_command(OP_COUNT,     32'hFFFF_FFFF);
        send_command(OP_ERASE_ALL, 32'hFFFF_FFFF);
        send_command(OP_ERASE_ONE, 32'h0000_0000);
        send_command(OP_ERASE_ONE, 32'h0000_0000);
        for (int i = 0; i < STORE_DEPTH; i++)
            send_command(OP_INSERT, i[0] ? 32'h8000_0001 : 32'h7FFF_FFFE);
        send_command(OP_INSERT,    32'h1234_5678);
        send_command(OP_COUNT,     32'h8000_0001);
        send_command(OP_ERASE_ALL, 32'h7FFF_FFFE);
        send_command(OP_ERASE_ALL, 32'h8000_0001);
    endtask

    task automatic run_random();
        int unsigned insert_pct;
        logic [1:0]  op;
        logic [31:0] value;
        insert_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 250 == 0)
                foreach (value_pool[k]) value_pool[k] = $urandom;
            // swing between filling and draining so the store hits full and empty
            if (n % 80 == 0) begin
                case ($urandom_range(0, 2))
                    0: insert_pct = 15;
                    1: insert_pct = 50;
                    default: insert_pct = 80;
                endcase
            end
            if ($urandom_range(0, 99) < insert_pct) begin
                op = OP_INSERT;
            end else begin
                case ($urandom_range(0, 2))
                    0: op = OP_ERASE_ALL;
                    1: op = OP_ERASE_ONE;
                    default: op = OP_COUNT;
                endcase
            end
            if ($urandom_range(0, 99) < 15)
                value = $urandom;
            else
                value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_command(op, value);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        if (stall_phase == '1) begin
            case ($urandom_range(0, 3))
                0: stall_mask = '1;
                1: stall_mask = $urandom;
                2: stall_mask = $urandom | $urandom;
                default: stall_mask = $urandom & $urandom;
            endcase
        end
        m_axis_tready <= stall_mask[stall_phase];
        stall_phase <= stall_phase + 5'd1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ multiset_match_store.f @@
design/mms_pkg.sv
design/mms_cell.sv
design/multiset_match_store.sv
design/mms_checker.sv
tb/tb_top.sv
